/* rtl/core/mpsm_pkg.sv */
package mpsm_pkg;

  localparam int DEF_MAX_NODES    = 256;
  localparam int DEF_ALPHABET     = 26;
  localparam int DEF_MAX_PATTERNS = 64;
  localparam int DEF_IDS_PER_NODE = 4;

  localparam int MAX_RESULTS  = 64;
  localparam int FIRST_LETTER = 97;

  typedef logic [2:0] action_t;
  typedef logic [7:0] symbol_t;
  typedef logic [2:0] status_t;
  typedef logic [5:0] pat_id_t;

  localparam action_t ACT_LETTER  = 3'd0;
  localparam action_t ACT_END     = 3'd1;
  localparam action_t ACT_BUILD   = 3'd2;
  localparam action_t ACT_TEXT    = 3'd3;
  localparam action_t ACT_RESTART = 3'd4;

  localparam status_t ST_ACK   = 3'd0;
  localparam status_t ST_ID    = 3'd1;
  localparam status_t ST_MATCH = 3'd2;
  localparam status_t ST_BUILT = 3'd3;
  localparam status_t ST_ERR   = 3'd4;

endpackage

/* rtl/core/mpsm_if.sv */
interface mpsm_in_if;
  logic              valid;
  logic              ready;
  mpsm_pkg::action_t action;
  mpsm_pkg::symbol_t symbol;

  modport source (output valid, output action, output symbol, input ready);
  modport sink (input valid, input action, input symbol, output ready);
endinterface

interface mpsm_out_if;
  logic              valid;
  logic              ready;
  mpsm_pkg::status_t status;
  mpsm_pkg::pat_id_t pattern_id;
  logic              last;

  modport source (output valid, output status, output pattern_id, output last, input ready);
  modport sink (input valid, input status, input pattern_id, input last, output ready);
endinterface

/* rtl/core/multi_pattern_string_matcher_unit.sv */
// Aho-Corasick matcher over the letters a to z. Pattern letters grow a trie, end-pattern
// beats assign ids, a build beat runs a breadth-first pass that fills suffix links, output
// links and the full transition table, and text letters then report every pattern id on
// the output-link chain, the final result flagged last. All state sits in block memories
// with registered reads, driven by one sequencer that handles one beat at a time.
// After reset a clearing pass writes zeros through the transition table, the link memory
// and the id counts before the first beat is accepted. A response waits in the result
// register while the sink is not ready. A text letter first walks its output chain through
// the link memory to count its matches; without matches, or on an error, one response
// follows, and with matches the chain is walked again, reporting one match at a time.
// The build visits every node and letter in breadth-first order, bound by the
// transition-table read port.
module multi_pattern_string_matcher_unit #(
  parameter int MAX_NODES    = mpsm_pkg::DEF_MAX_NODES,
  parameter int ALPHABET     = mpsm_pkg::DEF_ALPHABET,
  parameter int MAX_PATTERNS = mpsm_pkg::DEF_MAX_PATTERNS,
  parameter int IDS_PER_NODE = mpsm_pkg::DEF_IDS_PER_NODE
) (
  input  logic     clk,
  input  logic     rst_n,
  mpsm_in_if.sink  in_ch,
  mpsm_out_if.source out_ch
);
  import mpsm_pkg::*;

  localparam int NW  = $clog2(MAX_NODES);
  localparam int CW  = $clog2(ALPHABET);
  localparam int GD  = MAX_NODES * ALPHABET;
  localparam int GW  = $clog2(GD);
  localparam int ID  = MAX_NODES * IDS_PER_NODE;
  localparam int IW  = $clog2(ID);
  localparam int KW  = $clog2(IDS_PER_NODE + 1);
  localparam int PW  = $clog2(MAX_PATTERNS + 1);
  localparam int TW  = $clog2(ID + 1);
  localparam int RW  = $clog2(MAX_RESULTS + 1);

  localparam logic [4:0] S_CLR  = 5'd0;
  localparam logic [4:0] S_IDLE = 5'd1;
  localparam logic [4:0] S_RESP = 5'd2;
  localparam logic [4:0] S_PRD  = 5'd3;
  localparam logic [4:0] S_ERD  = 5'd4;
  localparam logic [4:0] S_TGO  = 5'd5;
  localparam logic [4:0] S_TW1  = 5'd6;
  localparam logic [4:0] S_TDEC = 5'd7;
  localparam logic [4:0] S_TN   = 5'd8;
  localparam logic [4:0] S_TI   = 5'd9;
  localparam logic [4:0] S_BPOP = 5'd10;
  localparam logic [4:0] S_BU   = 5'd11;
  localparam logic [4:0] S_BSU  = 5'd12;
  localparam logic [4:0] S_BC0  = 5'd13;
  localparam logic [4:0] S_BC1  = 5'd14;
  localparam logic [4:0] S_BC2  = 5'd15;
  localparam logic [4:0] S_BC3  = 5'd16;
  localparam logic [4:0] S_BC4  = 5'd17;

  typedef struct packed {
    logic [NW-1:0] suf;
    logic [NW-1:0] olink;
  } link_t;

  function automatic logic [GW-1:0] gaddr(input logic [NW-1:0] n, input logic [CW-1:0] ch);
    return GW'(int'(n) * ALPHABET + int'(ch));
  endfunction

  function automatic logic [IW-1:0] iaddr(input logic [NW-1:0] n, input logic [KW-1:0] j);
    return IW'(int'(n) * IDS_PER_NODE + int'(j));
  endfunction

  // Memories.
  logic [NW-1:0] goto_mem [GD];
  link_t         link_mem [MAX_NODES];
  logic [KW-1:0] cnt_mem  [MAX_NODES];
  pat_id_t       id_mem   [ID];
  logic [NW-1:0] q_mem    [MAX_NODES];

  logic [GW-1:0] g_ra, g_wa;
  logic [NW-1:0] g_wd, n_ra, l_wa, cnt_wa, q_wa, q_wd, q_ra;
  logic [IW-1:0] i_ra, i_wa;
  link_t         l_wd;
  logic [KW-1:0] cnt_wd;
  pat_id_t       i_wd;
  logic          g_we, l_we, cnt_we, i_we, q_we;

  logic [NW-1:0] g_rd_r, q_rd_r;
  link_t         l_rd_r;
  logic [KW-1:0] c_rd_r;
  pat_id_t       i_rd_r;

  always_ff @(posedge clk) begin
    if (g_we) goto_mem[g_wa] <= g_wd;
    if (l_we) link_mem[l_wa] <= l_wd;
    if (cnt_we) cnt_mem[cnt_wa] <= cnt_wd;
    if (i_we) id_mem[i_wa] <= i_wd;
    if (q_we) q_mem[q_wa] <= q_wd;
    g_rd_r <= goto_mem[g_ra];
    l_rd_r <= link_mem[n_ra];
    c_rd_r <= cnt_mem[n_ra];
    i_rd_r <= id_mem[i_ra];
    q_rd_r <= q_mem[q_ra];
  end

  // Sequencer registers.
  logic [4:0]    state_r, state_nxt;
  logic          built_r, built_nxt;
  logic [NW:0]   nc_r, nc_nxt;
  logic [PW-1:0] pc_r, pc_nxt;
  logic [NW-1:0] cursor_r, cursor_nxt, text_r, text_nxt;
  logic [GW-1:0] ga_r, ga_nxt, clr_r, clr_nxt;
  logic [CW-1:0] c_r, c_nxt;
  logic [NW-1:0] u_r, u_nxt, su_r, su_nxt, v_r, v_nxt, s_r, s_nxt, olink_r, olink_nxt;
  logic [NW:0]   head_r, head_nxt, tail_r, tail_nxt;
  logic [TW-1:0] total_r, total_nxt;
  logic [RW-1:0] k_r, k_nxt;
  logic [KW-1:0] i_r, i_nxt, cnt_r, cnt_nxt;
  status_t       pend_st_r, pend_st_nxt;
  pat_id_t       pend_id_r, pend_id_nxt;
  logic          out_valid_r, out_valid_nxt, out_last_r, out_last_nxt;
  status_t       out_st_r, out_st_nxt;
  pat_id_t       out_id_r, out_id_nxt;

  logic [8:0]    sym_off;
  logic          ok;
  logic [CW-1:0] c_in;
  logic          out_free;
  logic [NW-1:0] s_comb;
  logic          next_c;
  logic          is_last;

  assign sym_off  = {1'b0, in_ch.symbol} - 9'(FIRST_LETTER);
  assign ok       = (int'(in_ch.symbol) >= FIRST_LETTER) && (int'(sym_off) < ALPHABET);
  assign c_in     = ok ? CW'(sym_off) : '0;
  assign out_free = !out_valid_r || out_ch.ready;
  assign in_ch.ready = (state_r == S_IDLE);
  assign s_comb   = (u_r == '0) ? '0 : g_rd_r;
  assign is_last  = (int'(k_r) + 1 == int'(total_r));

  always_comb begin
    state_nxt   = state_r;
    built_nxt   = built_r;
    nc_nxt      = nc_r;
    pc_nxt      = pc_r;
    cursor_nxt  = cursor_r;
    text_nxt    = text_r;
    ga_nxt      = ga_r;
    clr_nxt     = clr_r;
    c_nxt       = c_r;
    u_nxt       = u_r;
    su_nxt      = su_r;
    v_nxt       = v_r;
    s_nxt       = s_r;
    olink_nxt   = olink_r;
    head_nxt    = head_r;
    tail_nxt    = tail_r;
    total_nxt   = total_r;
    k_nxt       = k_r;
    i_nxt       = i_r;
    cnt_nxt     = cnt_r;
    pend_st_nxt = pend_st_r;
    pend_id_nxt = pend_id_r;
    out_st_nxt  = out_st_r;
    out_id_nxt  = out_id_r;
    out_last_nxt = out_last_r;
    out_valid_nxt = out_ch.ready ? 1'b0 : out_valid_r;

    g_ra = ga_r;  n_ra = v_r;  i_ra = iaddr(v_r, i_r);  q_ra = head_r[NW-1:0];
    g_we = 1'b0;  g_wa = ga_r;  g_wd = '0;
    l_we = 1'b0;  l_wa = v_r;   l_wd = '0;
    cnt_we = 1'b0; cnt_wa = cursor_r; cnt_wd = '0;
    i_we = 1'b0;  i_wa = '0;    i_wd = '0;
    q_we = 1'b0;  q_wa = tail_r[NW-1:0]; q_wd = v_r;
    next_c = 1'b0;

    unique case (state_r)
      S_CLR: begin
        g_we = 1'b1;
        g_wa = clr_r;
        if (int'(clr_r) < MAX_NODES) begin
          l_we   = 1'b1;
          l_wa   = NW'(clr_r);
          cnt_we = 1'b1;
          cnt_wa = NW'(clr_r);
        end
        clr_nxt = clr_r + 1'b1;
        if (int'(clr_r) == GD - 1) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_ch.valid) begin
          pend_st_nxt = ST_ERR;
          pend_id_nxt = '0;
          state_nxt   = S_RESP;
          unique case (in_ch.action)
            ACT_LETTER: begin
              if (!built_r && ok) begin
                g_ra      = gaddr(cursor_r, c_in);
                ga_nxt    = g_ra;
                state_nxt = S_PRD;
              end
            end
            ACT_END: begin
              if (!built_r && int'(pc_r) < MAX_PATTERNS) begin
                n_ra      = cursor_r;
                state_nxt = S_ERD;
              end
            end
            ACT_BUILD: begin
              cursor_nxt = '0;
              if (built_r) begin
                pend_st_nxt = ST_BUILT;
              end else begin
                q_we      = 1'b1;
                q_wa      = '0;
                q_wd      = '0;
                head_nxt  = '0;
                tail_nxt  = (NW+1)'(1);
                state_nxt = S_BPOP;
              end
            end
            ACT_TEXT: begin
              if (built_r && ok) begin
                g_ra      = gaddr(text_r, c_in);
                state_nxt = S_TGO;
              end
            end
            ACT_RESTART: begin
              text_nxt    = '0;
              pend_st_nxt = ST_ACK;
            end
            default: ;
          endcase
        end
      end
      S_RESP: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_st_nxt    = pend_st_r;
          out_id_nxt    = pend_id_r;
          out_last_nxt  = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      S_PRD: begin
        pend_st_nxt = ST_ACK;
        state_nxt   = S_RESP;
        if (g_rd_r == '0) begin
          if (int'(nc_r) >= MAX_NODES) begin
            pend_st_nxt = ST_ERR;
          end else begin
            g_we       = 1'b1;
            g_wd       = nc_r[NW-1:0];
            cursor_nxt = nc_r[NW-1:0];
            nc_nxt     = nc_r + 1'b1;
          end
        end else begin
          cursor_nxt = g_rd_r;
        end
      end
      S_ERD: begin
        state_nxt = S_RESP;
        if (int'(c_rd_r) >= IDS_PER_NODE) begin
          pend_st_nxt = ST_ERR;
        end else begin
          i_we        = 1'b1;
          i_wa        = iaddr(cursor_r, c_rd_r);
          i_wd        = pat_id_t'(pc_r);
          cnt_we      = 1'b1;
          cnt_wd      = c_rd_r + 1'b1;
          cursor_nxt  = '0;
          pend_st_nxt = ST_ID;
          pend_id_nxt = pat_id_t'(pc_r);
          pc_nxt      = pc_r + 1'b1;
        end
      end
      S_TGO: begin
        u_nxt     = g_rd_r;
        total_nxt = '0;
        n_ra      = g_rd_r;
        state_nxt = (g_rd_r == '0) ? S_TDEC : S_TW1;
      end
      S_TW1: begin
        // One chain node per cycle: count its ids and follow its output link.
        total_nxt = total_r + TW'(c_rd_r);
        n_ra      = l_rd_r.olink;
        if (l_rd_r.olink == '0) state_nxt = S_TDEC;
      end
      S_TDEC: begin
        pend_id_nxt = '0;
        if (int'(total_r) > MAX_RESULTS) begin
          pend_st_nxt = ST_ERR;
          state_nxt   = S_RESP;
        end else begin
          text_nxt = u_r;
          if (total_r == '0) begin
            pend_st_nxt = ST_ACK;
            state_nxt   = S_RESP;
          end else begin
            k_nxt     = '0;
            v_nxt     = u_r;
            n_ra      = u_r;
            state_nxt = S_TN;
          end
        end
      end
      S_TN: begin
        if (c_rd_r == '0) begin
          v_nxt = l_rd_r.olink;
          n_ra  = l_rd_r.olink;
        end else begin
          cnt_nxt   = c_rd_r;
          olink_nxt = l_rd_r.olink;
          i_nxt     = '0;
          i_ra      = iaddr(v_r, '0);
          state_nxt = S_TI;
        end
      end
      S_TI: begin
        n_ra = olink_r;
        // Hold the id read address while the output stalls.
        i_ra = iaddr(v_r, out_free ? i_r + 1'b1 : i_r);
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_st_nxt    = ST_MATCH;
          out_id_nxt    = i_rd_r;
          out_last_nxt  = is_last;
          k_nxt         = k_r + 1'b1;
          if (is_last) begin
            state_nxt = S_IDLE;
          end else if (i_r + 1'b1 < cnt_r) begin
            i_nxt = i_r + 1'b1;
          end else begin
            v_nxt     = olink_r;
            state_nxt = S_TN;
          end
        end
      end
      S_BPOP: begin
        q_ra      = head_r[NW-1:0];
        state_nxt = S_BU;
      end
      S_BU: begin
        u_nxt     = q_rd_r;
        head_nxt  = head_r + 1'b1;
        n_ra      = q_rd_r;
        state_nxt = S_BSU;
      end
      S_BSU: begin
        su_nxt    = l_rd_r.suf;
        c_nxt     = '0;
        state_nxt = S_BC0;
      end
      S_BC0: begin
        g_ra      = gaddr(u_r, c_r);
        state_nxt = S_BC1;
      end
      S_BC1: begin
        v_nxt = g_rd_r;
        g_ra  = gaddr(su_r, c_r);
        if (g_rd_r == '0) begin
          if (u_r != '0) state_nxt = S_BC2;
          else next_c = 1'b1;
        end else begin
          state_nxt = S_BC3;
        end
      end
      S_BC2: begin
        // Missing edge inherits the suffix node's transition.
        g_we   = 1'b1;
        g_wa   = gaddr(u_r, c_r);
        g_wd   = g_rd_r;
        next_c = 1'b1;
      end
      S_BC3: begin
        s_nxt     = s_comb;
        n_ra      = s_comb;
        state_nxt = S_BC4;
      end
      S_BC4: begin
        l_we       = 1'b1;
        l_wa       = v_r;
        l_wd.suf   = s_r;
        l_wd.olink = (c_rd_r == '0) ? l_rd_r.olink : s_r;
        if (int'(tail_r) < MAX_NODES) begin
          q_we     = 1'b1;
          tail_nxt = tail_r + 1'b1;
        end
        next_c = 1'b1;
      end
      default: state_nxt = S_IDLE;
    endcase

    if (next_c) begin
      if (int'(c_r) == ALPHABET - 1) begin
        if (head_r < tail_nxt) begin
          state_nxt = S_BPOP;
        end else begin
          built_nxt   = 1'b1;
          pend_st_nxt = ST_BUILT;
          pend_id_nxt = '0;
          state_nxt   = S_RESP;
        end
      end else begin
        c_nxt     = c_r + 1'b1;
        state_nxt = S_BC0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_r       <= '0;
      built_r     <= 1'b0;
      nc_r        <= (NW+1)'(1);
      pc_r        <= '0;
      cursor_r    <= '0;
      text_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      built_r     <= built_nxt;
      nc_r        <= nc_nxt;
      pc_r        <= pc_nxt;
      cursor_r    <= cursor_nxt;
      text_r      <= text_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ga_r      <= ga_nxt;
    c_r       <= c_nxt;
    u_r       <= u_nxt;
    su_r      <= su_nxt;
    v_r       <= v_nxt;
    s_r       <= s_nxt;
    olink_r   <= olink_nxt;
    head_r    <= head_nxt;
    tail_r    <= tail_nxt;
    total_r   <= total_nxt;
    k_r       <= k_nxt;
    i_r       <= i_nxt;
    cnt_r     <= cnt_nxt;
    pend_st_r <= pend_st_nxt;
    pend_id_r <= pend_id_nxt;
    out_st_r  <= out_st_nxt;
    out_id_r  <= out_id_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.status     = out_st_r;
  assign out_ch.pattern_id = out_id_r;
  assign out_ch.last       = out_last_r;

endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
  import mpsm_pkg::*;

  localparam int N_NODES = DEF_MAX_NODES;
  localparam int N_LET   = DEF_ALPHABET;
  localparam int N_PAT   = DEF_MAX_PATTERNS;
  localparam int N_IDS   = DEF_IDS_PER_NODE;
  localparam int CYCLE_LIMIT = 1500000;

  typedef struct packed {
    status_t status;
    pat_id_t pattern_id;
    logic    last;
  } match_result_t;

  class match_scoreboard;
    int unsigned goto_tbl [N_NODES*N_LET];
    int unsigned fail_link [N_NODES];
    int unsigned dict_link [N_NODES];
    int unsigned id_cnt [N_NODES];
    int unsigned id_mem [N_NODES*N_IDS];
    int unsigned node_total;
    int unsigned pat_total;
    int unsigned cursor;
    int unsigned text_pos;
    bit          is_built;
    match_result_t pending_results[$];
    int mismatches;
    int matches_seen;

    function new();
      for (int i = 0; i < N_NODES*N_LET; i++) goto_tbl[i] = 0;
      for (int i = 0; i < N_NODES; i++) begin
        fail_link[i] = 0;
        dict_link[i] = 0;
        id_cnt[i] = 0;
      end
      node_total = 1;
      pat_total = 0;
      cursor = 0;
      text_pos = 0;
      is_built = 0;
      mismatches = 0;
      matches_seen = 0;
    endfunction

    function void push_result(status_t st, int unsigned id, bit lst);
      match_result_t r;
      r.status = st;
      r.pattern_id = id[5:0];
      r.last = lst;
      pending_results = {pending_results, r};
    endfunction

    function void build_links();
      int unsigned fifo [N_NODES];
      int unsigned head, tail, u, v, s;
      head = 0;
      tail = 1;
      fifo[0] = 0;
      while (head < tail) begin
        u = fifo[head];
        head++;
        for (int c = 0; c < N_LET; c++) begin
          v = goto_tbl[u*N_LET + c];
          if (v == 0) begin
            if (u != 0) goto_tbl[u*N_LET + c] = goto_tbl[fail_link[u]*N_LET + c];
          end else begin
            fail_link[v] = (u == 0) ? 0 : goto_tbl[fail_link[u]*N_LET + c];
            s = fail_link[v];
            dict_link[v] = (id_cnt[s] == 0) ? dict_link[s] : s;
            if (tail < N_NODES) begin
              fifo[tail] = v;
              tail++;
            end
          end
        end
      end
    endfunction

    // Works out every result that one accepted beat causes.
    function void note_input(action_t act, symbol_t sym);
      bit ok;
      int unsigned c, u, v, total, k, steps;
      ok = (sym >= FIRST_LETTER) && (sym < FIRST_LETTER + N_LET);
      c = ok ? sym - FIRST_LETTER : 0;
      case (act)
        ACT_LETTER: begin
          if (!is_built && ok) begin
            v = goto_tbl[cursor*N_LET + c];
            if (v == 0 && node_total < N_NODES) begin
              v = node_total;
              node_total++;
              goto_tbl[cursor*N_LET + c] = v;
            end
            if (v != 0) begin
              cursor = v;
              push_result(ST_ACK, 0, 1);
              return;
            end
          end
        end
        ACT_END: begin
          if (!is_built && pat_total < N_PAT && id_cnt[cursor] < N_IDS) begin
            id_mem[cursor*N_IDS + id_cnt[cursor]] = pat_total;
            id_cnt[cursor]++;
            push_result(ST_ID, pat_total, 1);
            pat_total++;
            cursor = 0;
            return;
          end
        end
        ACT_BUILD: begin
          if (!is_built) build_links();
          is_built = 1;
          cursor = 0;
          push_result(ST_BUILT, 0, 1);
          return;
        end
        ACT_TEXT: begin
          if (is_built && ok) begin
            u = goto_tbl[text_pos*N_LET + c];
            total = 0;
            v = u;
            steps = 0;
            while (v != 0 && steps < N_NODES) begin
              total += id_cnt[v];
              v = dict_link[v];
              steps++;
            end
            if (total <= MAX_RESULTS) begin
              text_pos = u;
              if (total == 0) begin
                push_result(ST_ACK, 0, 1);
                return;
              end
              k = 0;
              v = u;
              steps = 0;
              while (v != 0 && steps < N_NODES) begin
                for (int i = 0; i < id_cnt[v]; i++) begin
                  k++;
                  push_result(ST_MATCH, id_mem[v*N_IDS + i], k == total);
                end
                v = dict_link[v];
                steps++;
              end
              return;
            end
          end
        end
        ACT_RESTART: begin
          text_pos = 0;
          push_result(ST_ACK, 0, 1);
          return;
        end
        default: ;
      endcase
      push_result(ST_ERR, 0, 1);
    endfunction

    function void check_result(status_t st, pat_id_t id, logic lst);
      match_result_t exp_r;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: status %0d id %0d last %0d", st, id, lst);
        return;
      end
      exp_r = pending_results.pop_front();
      if (st == ST_MATCH) matches_seen++;
      if (exp_r.status !== st || exp_r.pattern_id !== id || exp_r.last !== lst) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected status %0d id %0d last %0d, got %0d %0d %0d",
                   exp_r.status, exp_r.pattern_id, exp_r.last, st, id, lst);
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  mpsm_in_if  in_ch();
  mpsm_out_if out_ch();
  match_scoreboard sb;
  bit   quiet_phase;
  int   cycle_count;
  int   out_hold;
  int   beats_sent;

  multi_pattern_string_matcher_unit dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("FAIL multi_pattern_string_matcher_unit");
      $finish;
    end
  end

  // Result side: check each accepted beat and throttle ready in bursts.
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      sb.check_result(out_ch.status, out_ch.pattern_id, out_ch.last);
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      out_hold <= 0;
    end else if (out_hold > 0) begin
      out_ch.ready <= 1'b0;
      out_hold <= out_hold - 1;
    end else if (!quiet_phase && $urandom_range(0, 5) == 0) begin
      out_ch.ready <= 1'b0;
      out_hold <= $urandom_range(0, 9);
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  task automatic send_beat(action_t act, symbol_t sym);
    in_ch.valid  <= 1'b1;
    in_ch.action <= act;
    in_ch.symbol <= sym;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_input(act, sym);
    beats_sent++;
    if (!quiet_phase && $urandom_range(0, 4) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
  endtask

  function automatic symbol_t rand_letter(int span);
    return symbol_t'(FIRST_LETTER + $urandom_range(0, span - 1));
  endfunction

  initial begin
    sb = new();
    quiet_phase = 0;
    beats_sent = 0;
    rst_n = 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.action <= ACT_LETTER;
    in_ch.symbol <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: errors before build, empty pattern, per-node id overflow.
    send_beat(ACT_TEXT, "a");
    send_beat(action_t'(5), "a");
    send_beat(action_t'(6), 8'hff);
    send_beat(action_t'(7), 8'h00);
    send_beat(ACT_LETTER, 8'h00);
    send_beat(ACT_LETTER, 8'd96);
    send_beat(ACT_LETTER, 8'd123);
    send_beat(ACT_LETTER, 8'hff);
    send_beat(ACT_END, "a");
    send_beat(ACT_RESTART, "z");
    send_beat(ACT_LETTER, "a");
    send_beat(ACT_LETTER, "b");
    send_beat(ACT_LETTER, "c");
    send_beat(ACT_END, 8'h00);
    send_beat(ACT_LETTER, "b");
    send_beat(ACT_LETTER, "c");
    send_beat(ACT_END, 8'h00);
    for (int i = 0; i < 5; i++) begin
      send_beat(ACT_LETTER, "c");
      send_beat(ACT_END, 8'h00);
    end
    send_beat(ACT_LETTER, "z");
    send_beat(ACT_END, 8'h00);

    // Short patterns over a small alphabet so the text side matches often.
    for (int p = 0; p < 20; p++) begin
      int len;
      len = $urandom_range(1, 4);
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(0, 9) == 0) send_beat(ACT_LETTER, symbol_t'($urandom));
        else send_beat(ACT_LETTER, rand_letter(p < 14 ? 3 : N_LET));
      end
      send_beat(ACT_END, symbol_t'($urandom));
    end

    send_beat(ACT_BUILD, 8'h00);
    send_beat(ACT_BUILD, 8'hff);
    send_beat(ACT_LETTER, "a");
    send_beat(ACT_END, 8'h00);

    for (int i = 0; i < 130; i++) begin
      int pick;
      if (i == 100) quiet_phase = 1;
      pick = $urandom_range(0, 99);
      if (pick < 75) send_beat(ACT_TEXT, rand_letter(3));
      else if (pick < 85) send_beat(ACT_TEXT, rand_letter(N_LET));
      else if (pick < 90) send_beat(ACT_TEXT, symbol_t'($urandom));
      else if (pick < 94) send_beat(ACT_RESTART, symbol_t'($urandom));
      else send_beat(action_t'($urandom_range(0, 7)), symbol_t'($urandom));
    end
    in_ch.valid <= 1'b0;

    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);

    $display("Sent %0d beats: pattern entry, per-node id overflow, build and text scanning.",
             beats_sent);
    $display("Checked %0d match results across %0d trie nodes.", sb.matches_seen,
             sb.node_total);
    if (sb.mismatches == 0 && sb.pending_results.size() == 0) begin
      $display("PASS multi_pattern_string_matcher_unit");
    end else begin
      $display("%0d mismatches, %0d results missing", sb.mismatches,
               sb.pending_results.size());
      $display("FAIL multi_pattern_string_matcher_unit");
    end
    $finish;
  end

endmodule
